[src/assert_macros.svh]
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds at every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk_i, rst_n, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define CHK_NEXT(label, clk_i, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

[src/sps_pkg.sv]
// Package for the shortest path search block: sizes, codes and states.
package sps_pkg;
	localparam int MaxNodesDef = 64;
	localparam int MaxNbrDef = 4;
	localparam logic [15:0] Unreached = 16'hFFFF;
	localparam logic CmdLoad = 1'b0;
	localparam logic CmdRun = 1'b1;
	localparam logic CfgNodeCount = 1'b0;
	localparam logic CfgNbrCount = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_PICK,
		ST_RDSLOT,
		ST_RELAX,
		ST_OUTRD,
		ST_OUTWAIT,
		ST_OUTSEND
	} state_t;
endpackage

[src/sps_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module sps_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[src/sps_min_unit.sv]
// Shared compare and add unit: minimum tracking and relax sum with a saturation flag.
module sps_min_unit (
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic        a_lt_b,
	output logic        a_le_b,
	output logic [15:0] sum,
	output logic        sum_sat
);
	logic [16:0] wide;

	always_comb begin
		wide = {1'b0, a} + {1'b0, b};
		sum_sat = (wide >= 17'h0FFFF);
		sum = wide[15:0];
		a_lt_b = (a < b);
		a_le_b = (a <= b);
	end
endmodule

[src/shortest_path_search_top.sv]
// Top level of the shortest path search block: control sequencer and tables.
// A load word (command 0) writes one neighbor slot in the cycle it is accepted, so load
// words can follow back to back. A run word (command 1) clears all MAX_NODES entries of
// the node tables and seeds the source, if in range, with distance zero, then repeats
// rounds: a scan over all node_count entries of the distance table through one read port
// picks the lowest unsettled finite distance, lowest index first, then each of that
// node's neighbor_count slots is read and relaxed through one shared adder/comparator.
// The first round takes an in-range source directly. The run ends when the target settles
// or no reachable node is left; one result word per node in use then streams out in
// ascending order, the final one marked with tlast, and each word is read from the
// tables only after the previous one is accepted. tready stays low for the whole run.
module shortest_path_search_top import sps_pkg::*; #(
	parameter int MAX_NODES = MaxNodesDef,
	parameter int MAX_NEIGHBORS = MaxNbrDef
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_wdata,
	// input stream; tdata from bit 0: command, node, slot, weight, neighbor,
	// neighbor_present, source, target, zero pad
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	// output stream; tdata from bit 0: out_node, predecessor, has_predecessor,
	// distance, zero pad; tlast: last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int AW = $clog2(MAX_NODES * MAX_NEIGHBORS);
	localparam int CW = NW + 1;
	localparam int KW = $clog2(MAX_NEIGHBORS + 1);

	// field extraction
	logic        in_cmd;
	logic [5:0]  in_node, in_nbr, in_src, in_tgt;
	logic [1:0]  in_slot;
	logic [15:0] in_weight;
	logic        in_present;
	assign in_cmd = s_axis_tdata[0];
	assign in_node = s_axis_tdata[6:1];
	assign in_slot = s_axis_tdata[8:7];
	assign in_weight = s_axis_tdata[24:9];
	assign in_nbr = s_axis_tdata[30:25];
	assign in_present = s_axis_tdata[31];
	assign in_src = s_axis_tdata[37:32];
	assign in_tgt = s_axis_tdata[43:38];

	// config registers
	logic [6:0] node_count_q;
	logic [2:0] nbr_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 7'd64;
			nbr_count_q <= 3'd4;
		end else if (cfg_we) begin
			if (cfg_index == CfgNodeCount) node_count_q <= cfg_wdata;
			else nbr_count_q <= cfg_wdata[2:0];
		end
	end

	// clamp into range
	logic [CW-1:0] n_eff;
	logic [KW-1:0] nc_eff;
	always_comb begin
		if (node_count_q == 7'd0) n_eff = CW'(1);
		else if (32'(node_count_q) > MAX_NODES) n_eff = CW'(MAX_NODES);
		else n_eff = CW'(node_count_q);
		if (nbr_count_q == 3'd0) nc_eff = KW'(1);
		else if (32'(nbr_count_q) > MAX_NEIGHBORS) nc_eff = KW'(MAX_NEIGHBORS);
		else nc_eff = KW'(nbr_count_q);
	end

	// slot memories: weight, and {present, neighbor}
	logic          slot_we;
	logic [AW-1:0] slot_waddr, slot_raddr;
	logic [15:0]   w_rdata;
	logic [NW:0]   nb_rdata, nb_wdata;
	sps_ram #(.Width(16), .Depth(MAX_NODES * MAX_NEIGHBORS)) u_wram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(in_weight),
		.raddr(slot_raddr), .rdata(w_rdata));
	sps_ram #(.Width(NW + 1), .Depth(MAX_NODES * MAX_NEIGHBORS)) u_nram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(nb_wdata),
		.raddr(slot_raddr), .rdata(nb_rdata));

	// node tables: distance, {has_pred, pred}
	logic          d_we;
	logic [NW-1:0] d_waddr, d_raddr;
	logic [15:0]   d_wdata, d_rdata;
	logic [NW:0]   p_wdata, p_rdata;
	sps_ram #(.Width(16), .Depth(MAX_NODES)) u_dram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));
	sps_ram #(.Width(NW + 1), .Depth(MAX_NODES)) u_pram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(p_wdata),
		.raddr(d_raddr), .rdata(p_rdata));

	// settled marks: flip-flop row, one bit per node
	logic [MAX_NODES-1:0] settled_q;

	// sequencer registers
	state_t        state_q, state_d;
	logic [CW-1:0] idx_q;       // scan / output / init counter
	logic [CW-1:0] rd_idx_q;    // index of data arriving from table
	logic          rd_vld_q;
	logic [KW-1:0] slot_q;
	logic [NW-1:0] cur_q;
	logic [15:0]   cur_dist_q, best_q;
	logic [CW-1:0] best_idx_q;
	logic          best_vld_q;
	logic [CW-1:0] tgt_q;
	logic [NW-1:0] nb_q;
	logic [15:0]   sum_q;
	logic          sum_ok_q;

	// shared unit: compare for scan/relax, add for path sum
	logic [15:0] ua, ub, usum;
	logic        ult, ule, usat;
	sps_min_unit u_unit (.a(ua), .b(ub), .a_lt_b(ult), .a_le_b(ule),
		.sum(usum), .sum_sat(usat));

	logic [CW-1:0] src_ext;
	assign src_ext = CW'(in_src);
	assign s_axis_tready = (state_q == ST_IDLE);

	// table address for the next slot of the current node
	logic [AW-1:0] cur_slot_addr;
	assign cur_slot_addr = AW'(cur_q) * AW'(MAX_NEIGHBORS) + AW'(slot_q);

	always_comb begin
		slot_we = 1'b0;
		slot_waddr = AW'(in_node) * AW'(MAX_NEIGHBORS) + AW'(in_slot);
		nb_wdata = {in_present, NW'(in_nbr)};
		slot_raddr = cur_slot_addr;
		d_we = 1'b0;
		d_waddr = idx_q[NW-1:0];
		d_wdata = Unreached;
		p_wdata = '0;
		d_raddr = idx_q[NW-1:0];
		ua = d_rdata;
		ub = best_q;
		state_d = state_q;
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			if (in_cmd == CmdLoad) begin
				slot_we = (32'(in_node) < MAX_NODES) && (32'(in_slot) < MAX_NEIGHBORS);
			end else begin
				state_d = ST_INIT;
			end
		end
		case (state_q)
			ST_IDLE: ;
			ST_INIT: begin
				d_we = 1'b1;
				// seed the source with distance zero when it is in range
				if (sum_ok_q && idx_q[NW-1:0] == cur_q) d_wdata = '0;
				if (idx_q[NW-1:0] == NW'(MAX_NODES - 1)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// compare arriving distance against best so far
				if (!rd_vld_q && idx_q >= n_eff) state_d = ST_PICK;
				if (rd_vld_q && rd_idx_q == n_eff - CW'(1)) state_d = ST_PICK;
			end
			ST_PICK: begin
				if (!best_vld_q) state_d = ST_OUTRD;
				else if (best_idx_q == tgt_q) state_d = ST_OUTRD;
				else state_d = ST_RDSLOT;
			end
			ST_RDSLOT: begin
				// with rd_vld_q low the slot read is issued; with it high the read data is seen
				if (rd_vld_q) state_d = ST_RELAX;
				else if (slot_q >= nc_eff) state_d = ST_SCAN;
			end
			ST_RELAX: begin
				d_raddr = nb_q;
				ua = sum_q;
				ub = d_rdata;
				if (rd_vld_q) begin
					d_waddr = nb_q;
					d_wdata = sum_q;
					p_wdata = {1'b1, cur_q};
					d_we = sum_ok_q && ule;
					state_d = ST_RDSLOT;
				end
			end
			ST_OUTRD: state_d = ST_OUTWAIT;
			ST_OUTWAIT: state_d = ST_OUTSEND;
			ST_OUTSEND: begin
				if (m_axis_tready) begin
					if (m_axis_tlast) state_d = ST_IDLE;
					else state_d = ST_OUTRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_RDSLOT && rd_vld_q) begin
			ua = cur_dist_q;
			ub = w_rdata;
		end
	end

	logic [NW-1:0] sn_idx;
	assign sn_idx = nb_rdata[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			slot_q <= '0;
			settled_q <= '0;
			best_vld_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (s_axis_tvalid && in_cmd == CmdRun) begin
						settled_q <= '0;
						tgt_q <= CW'(in_tgt);
						best_q <= Unreached;
						best_vld_q <= 1'b0;
						cur_q <= in_src[NW-1:0];
						nb_q <= in_src[NW-1:0];
						sum_ok_q <= (src_ext < n_eff);
					end
				end
				ST_INIT: begin
					if (state_d == ST_SCAN) begin
						idx_q <= '0;
						rd_vld_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_SCAN: begin
					// first scan round of a run: take the source directly
					if (sum_ok_q && best_q == Unreached && !best_vld_q && idx_q == '0
							&& !rd_vld_q && settled_q == '0) begin
						// seed: mark by best directly (source distance zero)
						best_q <= '0;
						best_idx_q <= CW'(nb_q);
						best_vld_q <= 1'b1;
						idx_q <= n_eff;
					end else begin
						if (idx_q < n_eff) idx_q <= idx_q + CW'(1);
						rd_vld_q <= (idx_q < n_eff);
						rd_idx_q <= idx_q;
						if (rd_vld_q && !settled_q[rd_idx_q[NW-1:0]] && ult) begin
							best_q <= d_rdata;
							best_idx_q <= rd_idx_q;
							best_vld_q <= 1'b1;
						end
					end
				end
				ST_PICK: begin
					cur_q <= best_idx_q[NW-1:0];
					cur_dist_q <= best_q;
					slot_q <= '0;
					rd_vld_q <= 1'b0;
					sum_ok_q <= 1'b0;
					if (best_vld_q) settled_q[best_idx_q[NW-1:0]] <= 1'b1;
					if (!best_vld_q || best_idx_q == tgt_q) idx_q <= '0;
				end
				ST_RDSLOT: begin
					// with rd_vld_q low issue the read; with it high use the data
					if (!rd_vld_q) begin
						if (slot_q >= nc_eff) begin
							idx_q <= '0;
							best_q <= Unreached;
							best_vld_q <= 1'b0;
						end else begin
							rd_vld_q <= 1'b1;
						end
					end else begin
						nb_q <= sn_idx;
						sum_q <= usum;
						sum_ok_q <= nb_rdata[NW] && (CW'(sn_idx) < n_eff)
							&& !settled_q[sn_idx] && !usat;
						slot_q <= slot_q + KW'(1);
						rd_vld_q <= 1'b0;
					end
				end
				ST_RELAX: begin
					rd_vld_q <= !rd_vld_q;
				end
				ST_OUTRD: ;
				ST_OUTWAIT: begin
					m_axis_tvalid <= 1'b1;
					m_axis_tdata <= {3'b000, d_rdata, p_rdata[NW], 6'(p_rdata[NW-1:0]),
						6'(idx_q)};
					m_axis_tlast <= (idx_q == n_eff - CW'(1));
				end
				ST_OUTSEND: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						idx_q <= idx_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[src/sps_checker.sv]
// Port-level checker for the shortest path search block, with its bind.
`include "assert_macros.svh"
module sps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	logic out_acc;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	`CHK_ALWAYS(a_no_overlap, clk, arst_n, !(s_axis_tready && m_axis_tvalid), "input open")
	`CHK_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "moved")
	`CHK_NEXT(a_last_idle, clk, arst_n, out_acc && m_axis_tlast, !m_axis_tvalid, "word after last")
	`CHK_ALWAYS(a_pad, clk, arst_n, !m_axis_tvalid || m_axis_tdata[31:29] == 3'b000, "pad bits set")
endmodule

bind shortest_path_search_top sps_checker u_sps_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast));
